@@ design/ulsp_pkg.sv @@
package ulsp_pkg;

  localparam int ULSP_NUMBER_BITS = 24;
  localparam int ULSP_COORD_BITS = 16;
  localparam int ULSP_LEG_BITS = 13;
  localparam int ULSP_SCALE_BITS = 4;
  localparam int ULSP_CFG_IDX_BITS = 3;

  localparam logic [ULSP_SCALE_BITS-1:0] ULSP_SCALE_RESET = 4'd4;
  localparam logic [31:0] ULSP_LIMIT_RESET = 32'd10000000;

  localparam logic [ULSP_CFG_IDX_BITS-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [ULSP_CFG_IDX_BITS-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [ULSP_CFG_IDX_BITS-1:0] CFG_STEP_SCALE = 3'd2;
  localparam logic [ULSP_CFG_IDX_BITS-1:0] CFG_NUMBER_LIMIT = 3'd3;

  typedef enum logic [1:0] {
    HEAD_WEST,
    HEAD_SOUTH,
    HEAD_EAST,
    HEAD_NORTH
  } ulsp_head_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLACE_X,
    ST_PLACE_Y,
    ST_TEST,
    ST_EMIT
  } ulsp_state_e;

  typedef struct packed {
    logic done;
    logic prime;
  } ulsp_prm_sts_t;

endpackage

@@ design/ulam_spiral_prime_plotter_core.sv @@
// Primality test: trial division by 2, then by odd divisors up to floor(sqrt(n)), ending at
// the first that divides n; one remainder bit per cycle. No division is run past the limit
// or for numbers below four. Input is held off while an item runs, and a new item is taken
// while the last result waits.
// Reset (rst_ni low, asynchronous): walk not started, control and config registers to defaults.
module ulam_spiral_prime_plotter_core
  import ulsp_pkg::*;
#(
  parameter int NUMBER_BITS = ULSP_NUMBER_BITS,
  parameter int COORD_BITS  = ULSP_COORD_BITS,
  localparam int CFG_BITS   = (NUMBER_BITS > COORD_BITS) ? NUMBER_BITS : COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ULSP_CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]          cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         restart_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         valid_res_o,
  output logic [NUMBER_BITS-1:0]       number_o,
  output logic signed [COORD_BITS-1:0] pos_x_o,
  output logic signed [COORD_BITS-1:0] pos_y_o,
  output logic                         prime_flag_o,
  output logic                         at_limit_o
);

  logic [COORD_BITS-1:0]      origin_x_q;
  logic [COORD_BITS-1:0]      origin_y_q;
  logic [ULSP_SCALE_BITS-1:0] scale_q;
  logic [NUMBER_BITS-1:0]     limit_q;

  ulsp_state_e state_q, state_d;

  logic [NUMBER_BITS-1:0]   num_q, num_d;
  logic [COORD_BITS-1:0]    cell_x_q, cell_x_d;
  logic [COORD_BITS-1:0]    cell_y_q, cell_y_d;
  ulsp_head_e               heading_q, heading_d;
  logic [ULSP_LEG_BITS-1:0] leg_q, leg_d;
  logic [ULSP_LEG_BITS-1:0] prog_q, prog_d;
  logic                     second_q, second_d;
  logic                     vres_q, vres_d;
  logic [ULSP_LEG_BITS-1:0] prog_inc;

  logic [COORD_BITS-1:0] pos_x_q;
  logic [COORD_BITS-1:0] pos_y_q;
  logic [COORD_BITS-1:0] mul_cell;
  logic [COORD_BITS-1:0] mul_org;
  logic [COORD_BITS-1:0] place_sum;

  logic                   out_valid_q;
  logic                   out_vres_q;
  logic [NUMBER_BITS-1:0] out_num_q;
  logic [COORD_BITS-1:0]  out_pos_x_q;
  logic [COORD_BITS-1:0]  out_pos_y_q;
  logic                   out_prime_q;
  logic                   out_limit_q;

  logic                   in_accept;
  logic                   prm_start;
  logic                   place_x_en;
  logic                   place_y_en;
  logic                   emit_en;
  logic [NUMBER_BITS-1:0] prm_number;
  ulsp_prm_sts_t          prm_sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      scale_q    <= ULSP_SCALE_RESET;
      limit_q    <= NUMBER_BITS'(ULSP_LIMIT_RESET);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ORIGIN_X:     origin_x_q <= cfg_data_i[COORD_BITS-1:0];
        CFG_ORIGIN_Y:     origin_y_q <= cfg_data_i[COORD_BITS-1:0];
        CFG_STEP_SCALE:   scale_q    <= cfg_data_i[ULSP_SCALE_BITS-1:0];
        CFG_NUMBER_LIMIT: limit_q    <= cfg_data_i[NUMBER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_PLACE_X;
      ST_PLACE_X: state_d = ST_PLACE_Y;
      ST_PLACE_Y: state_d = ST_TEST;
      ST_TEST:    if (prm_sts.done) state_d = ST_EMIT;
      ST_EMIT:    if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    prm_start  = 1'b0;
    place_x_en = 1'b0;
    place_y_en = 1'b0;
    emit_en    = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_PLACE_X: begin
        prm_start  = 1'b1;
        place_x_en = 1'b1;
      end
      ST_PLACE_Y: place_y_en = 1'b1;
      ST_TEST: ;
      ST_EMIT: emit_en = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_accept = in_valid_i && in_ready_o;
  assign prog_inc  = prog_q + ULSP_LEG_BITS'(1);

  always_comb begin
    num_d     = num_q;
    cell_x_d  = cell_x_q;
    cell_y_d  = cell_y_q;
    heading_d = heading_q;
    leg_d     = leg_q;
    prog_d    = prog_q;
    second_d  = second_q;
    vres_d    = vres_q;
    if (in_accept) begin
      if (restart_i || (num_q == '0)) begin
        num_d     = NUMBER_BITS'(1);
        cell_x_d  = '0;
        cell_y_d  = '0;
        heading_d = HEAD_WEST;
        leg_d     = ULSP_LEG_BITS'(1);
        prog_d    = '0;
        second_d  = 1'b0;
        vres_d    = limit_q != '0;
      end else if (num_q >= limit_q) begin
        vres_d = 1'b0;
      end else begin
        num_d  = num_q + NUMBER_BITS'(1);
        vres_d = 1'b1;
        case (heading_q)
          HEAD_WEST:  cell_x_d = cell_x_q - COORD_BITS'(1);
          HEAD_SOUTH: cell_y_d = cell_y_q + COORD_BITS'(1);
          HEAD_EAST:  cell_x_d = cell_x_q + COORD_BITS'(1);
          default:    cell_y_d = cell_y_q - COORD_BITS'(1);
        endcase
        prog_d = prog_inc;
        if (prog_inc == leg_q) begin
          prog_d    = '0;
          heading_d = ulsp_head_e'(2'(heading_q + 2'd1));
          if (second_q) begin
            leg_d    = leg_q + ULSP_LEG_BITS'(1);
            second_d = 1'b0;
          end else begin
            second_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_q       <= '0;
      cell_x_q    <= '0;
      cell_y_q    <= '0;
      heading_q   <= HEAD_WEST;
      leg_q       <= ULSP_LEG_BITS'(1);
      prog_q      <= '0;
      second_q    <= 1'b0;
      vres_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      num_q     <= num_d;
      cell_x_q  <= cell_x_d;
      cell_y_q  <= cell_y_d;
      heading_q <= heading_d;
      leg_q     <= leg_d;
      prog_q    <= prog_d;
      second_q  <= second_d;
      vres_q    <= vres_d;
      if (emit_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // shared scale multiply and add for both axes
  assign mul_cell  = place_y_en ? cell_y_q : cell_x_q;
  assign mul_org   = place_y_en ? origin_y_q : origin_x_q;
  assign place_sum = mul_org + COORD_BITS'(scale_q) * mul_cell;

  always_ff @(posedge clk_i) begin
    if (place_x_en) begin
      pos_x_q <= place_sum;
    end
    if (place_y_en) begin
      pos_y_q <= place_sum;
    end
  end

  assign prm_number = vres_q ? num_q : '0;

  ulsp_prime_div #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_prime_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (prm_start),
    .number_i(prm_number),
    .sts_o   (prm_sts)
  );

  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      out_vres_q  <= vres_q;
      out_num_q   <= vres_q ? num_q : '0;
      out_pos_x_q <= vres_q ? pos_x_q : '0;
      out_pos_y_q <= vres_q ? pos_y_q : '0;
      out_prime_q <= vres_q && prm_sts.prime;
      out_limit_q <= vres_q && (num_q == limit_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign valid_res_o  = out_vres_q;
  assign number_o     = out_num_q;
  assign pos_x_o      = $signed(out_pos_x_q);
  assign pos_y_o      = $signed(out_pos_y_q);
  assign prime_flag_o = out_prime_q;
  assign at_limit_o   = out_limit_q;

endmodule

@@ design/ulsp_prime_div.sv @@
module ulsp_prime_div
  import ulsp_pkg::*;
#(
  parameter int NUMBER_BITS = ULSP_NUMBER_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NUMBER_BITS-1:0] number_i,
  output ulsp_prm_sts_t          sts_o
);

  localparam int DIV_BITS = (NUMBER_BITS + 1) / 2 + 2;
  localparam int SQ_BITS = 2 * DIV_BITS;
  localparam int BIT_W = $clog2(NUMBER_BITS);
  localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(NUMBER_BITS - 1);

  logic [NUMBER_BITS-1:0] num_q;
  logic [DIV_BITS-1:0]    div_q;
  logic [SQ_BITS-1:0]     sq_q;
  logic [DIV_BITS-1:0]    rem_q;
  logic [BIT_W-1:0]       bit_q;
  logic                   busy_q;
  logic                   done_q;
  logic                   prime_q;

  logic [DIV_BITS:0]   rem_sh;
  logic [DIV_BITS:0]   rem_nx;
  logic                rem_ge;
  logic                last_bit;
  logic                div_two;
  logic [DIV_BITS-1:0] div_nx;
  logic [SQ_BITS-1:0]  sq_nx;
  logic                sq_over;

  // one restoring division step per cycle
  assign rem_sh   = {rem_q, num_q[bit_q]};
  assign rem_ge   = rem_sh >= {1'b0, div_q};
  assign rem_nx   = rem_ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
  assign last_bit = bit_q == '0;

  // divisors 2, then odd ones; square tracked incrementally
  assign div_two = div_q == DIV_BITS'(2);
  assign div_nx  = div_two ? DIV_BITS'(3) : (div_q + DIV_BITS'(2));
  assign sq_nx   = div_two ? SQ_BITS'(9)
                           : (sq_q + SQ_BITS'({div_q, 2'b00}) + SQ_BITS'(4));
  assign sq_over = sq_nx > SQ_BITS'(num_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      prime_q <= 1'b0;
    end else if (start_i) begin
      if (number_i < NUMBER_BITS'(2)) begin
        busy_q  <= 1'b0;
        done_q  <= 1'b1;
        prime_q <= 1'b0;
      end else if (number_i < NUMBER_BITS'(4)) begin
        busy_q  <= 1'b0;
        done_q  <= 1'b1;
        prime_q <= 1'b1;
      end else begin
        busy_q  <= 1'b1;
        done_q  <= 1'b0;
        prime_q <= 1'b0;
      end
    end else if (busy_q && last_bit) begin
      if (rem_nx == '0) begin
        busy_q  <= 1'b0;
        done_q  <= 1'b1;
        prime_q <= 1'b0;
      end else if (sq_over) begin
        busy_q  <= 1'b0;
        done_q  <= 1'b1;
        prime_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= number_i;
      div_q <= DIV_BITS'(2);
      sq_q  <= SQ_BITS'(4);
      rem_q <= '0;
      bit_q <= BIT_TOP;
    end else if (busy_q) begin
      if (!last_bit) begin
        rem_q <= rem_nx[DIV_BITS-1:0];
        bit_q <= bit_q - BIT_W'(1);
      end else begin
        div_q <= div_nx;
        sq_q  <= sq_nx;
        rem_q <= '0;
        bit_q <= BIT_TOP;
      end
    end
  end

  assign sts_o.done  = done_q;
  assign sts_o.prime = prime_q;

endmodule

@@ verif/testbench.sv @@
module testbench;
  import ulsp_pkg::*;

  localparam int NUM_W       = ULSP_NUMBER_BITS;
  localparam int CRD_W       = ULSP_COORD_BITS;
  localparam int DATA_W      = (NUM_W > CRD_W) ? NUM_W : CRD_W;
  localparam int RANDOM_ITEMS = 110;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LAST_INDEX   = (1 << ULSP_CFG_IDX_BITS) - 1;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] number;
    logic [CRD_W-1:0] pos_x;
    logic [CRD_W-1:0] pos_y;
    logic             prime;
    logic             at_limit;
  } spiral_cell_t;

  class spiral_scoreboard;
    logic [CRD_W-1:0]           org_x, org_y;
    logic [ULSP_SCALE_BITS-1:0] scale;
    logic [NUM_W-1:0]           limit;
    logic [NUM_W-1:0]           num;
    logic [CRD_W-1:0]           cx, cy;
    ulsp_head_e                 head;
    logic [ULSP_LEG_BITS-1:0]   leg_len, leg_pos;
    bit                         second;
    spiral_cell_t               cells_q[$];
    int errors, n_checked, n_valid, n_primes, n_at_limit;

    function new();
      org_x = '0;
      org_y = '0;
      scale = ULSP_SCALE_RESET;
      limit = ULSP_LIMIT_RESET[NUM_W-1:0];
      num   = '0;
      start_walk();
    endfunction

    function void start_walk();
      cx = '0;
      cy = '0;
      head = HEAD_WEST;
      leg_len = ULSP_LEG_BITS'(1);
      leg_pos = '0;
      second = 0;
    endfunction

    function bit trial_prime(logic [NUM_W-1:0] n);
      int unsigned d;
      if (n < 2) return 0;
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) return 0;
      end
      return 1;
    endfunction

    function void write_reg(logic [ULSP_CFG_IDX_BITS-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        CFG_ORIGIN_X:     org_x = data[CRD_W-1:0];
        CFG_ORIGIN_Y:     org_y = data[CRD_W-1:0];
        CFG_STEP_SCALE:   scale = data[ULSP_SCALE_BITS-1:0];
        CFG_NUMBER_LIMIT: limit = data[NUM_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(bit restart);
      spiral_cell_t c;
      bit live;
      c = '0;
      if (restart || num == 0) begin
        start_walk();
        num = NUM_W'(1);
        live = (limit >= 1);
      end else if (num >= limit) begin
        live = 0;
      end else begin
        case (head)
          HEAD_WEST:  cx = cx - 1'b1;
          HEAD_SOUTH: cy = cy + 1'b1;
          HEAD_EAST:  cx = cx + 1'b1;
          default:    cy = cy - 1'b1;
        endcase
        leg_pos = leg_pos + 1'b1;
        if (leg_pos == leg_len) begin
          leg_pos = '0;
          head = ulsp_head_e'(2'(head + 1));
          if (second) begin
            leg_len = leg_len + 1'b1;
            second = 0;
          end else begin
            second = 1;
          end
        end
        num = num + 1'b1;
        live = 1;
      end
      if (live) begin
        c.valid    = 1'b1;
        c.number   = num;
        c.pos_x    = org_x + CRD_W'(scale) * cx;
        c.pos_y    = org_y + CRD_W'(scale) * cy;
        c.prime    = trial_prime(num);
        c.at_limit = (num == limit);
      end
      cells_q.push_back(c);
    endfunction

    function void compare(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(spiral_cell_t got);
      spiral_cell_t exp_c;
      if (cells_q.size() == 0) begin
        $error("result with no item waiting: number %0d", got.number);
        errors++;
        return;
      end
      exp_c = cells_q.pop_front();
      compare("valid_res", exp_c.valid, got.valid);
      compare("number", exp_c.number, got.number);
      compare("pos_x", $signed(exp_c.pos_x), $signed(got.pos_x));
      compare("pos_y", $signed(exp_c.pos_y), $signed(got.pos_y));
      compare("prime_flag", exp_c.prime, got.prime);
      compare("at_limit", exp_c.at_limit, got.at_limit);
      n_checked++;
      if (exp_c.valid) n_valid++;
      if (exp_c.prime) n_primes++;
      if (exp_c.at_limit) n_at_limit++;
    endfunction

    function int pending();
      return cells_q.size();
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [ULSP_CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]            cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic                         restart_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic                         valid_res_o;
  logic [NUM_W-1:0]             number_o;
  logic signed [CRD_W-1:0]      pos_x_o;
  logic signed [CRD_W-1:0]      pos_y_o;
  logic                         prime_flag_o;
  logic                         at_limit_o;

  spiral_scoreboard sb;
  bit calm = 0;
  bit hold_req = 0;
  int settings_done = 0;
  int restarts_sent = 0;
  int items_sent = 0;

  ulam_spiral_prime_plotter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .valid_res_o (valid_res_o),
    .number_o    (number_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .prime_flag_o(prime_flag_o),
    .at_limit_o  (at_limit_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_input(restart_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result({valid_res_o, number_o, pos_x_o, pos_y_o, prime_flag_o, at_limit_o});
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  initial begin : sink
    int n;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 0;
        out_ready_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 16);
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic offer(input bit r);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (r) restarts_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.n_checked < items_sent || sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [ULSP_CFG_IDX_BITS-1:0] idx, input logic [DATA_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(input logic [CRD_W-1:0] ox, input logic [CRD_W-1:0] oy,
                           input logic [ULSP_SCALE_BITS-1:0] sc, input logic [NUM_W-1:0] lim);
    put_reg(CFG_ORIGIN_X, {(DATA_W-CRD_W)'($urandom), ox});
    put_reg(CFG_ORIGIN_Y, {(DATA_W-CRD_W)'($urandom), oy});
    put_reg(CFG_STEP_SCALE, {(DATA_W-ULSP_SCALE_BITS)'($urandom), sc});
    put_reg(CFG_NUMBER_LIMIT, DATA_W'(lim));
    if ($urandom_range(0, 2) == 0) begin
      put_reg(ULSP_CFG_IDX_BITS'($urandom_range(CFG_NUMBER_LIMIT + 1, LAST_INDEX)),
              DATA_W'($urandom));
    end
    cfg_valid_i <= 1'b0;
    settings_done++;
  endtask

  function automatic logic [CRD_W-1:0] pick_origin();
    case ($urandom_range(0, 4))
      0: return {1'b0, {(CRD_W-1){1'b1}}};
      1: return {1'b1, {(CRD_W-1){1'b0}}};
      default: return CRD_W'($urandom);
    endcase
  endfunction

  function automatic logic [NUM_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return NUM_W'($urandom_range(1, 8));
      1: return NUM_W'($urandom_range(9, 80));
      2: return NUM_W'($urandom_range(81, 300));
      3: return {NUM_W{1'b1}};
      default: return NUM_W'($urandom) | NUM_W'(1'b1);
    endcase
  endfunction

  initial begin : stimulus
    int phase;
    int len;
    int rand_items;
    sb = new();
    phase = 0;
    rand_items = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: first advance starts the walk, then round all four headings
    repeat (10) offer(1'b0);
    offer(1'b1);
    offer(1'b0);

    wait_idle();
    configure(16'd1234, 16'hFF00, 4'd0, 24'd1);
    offer(1'b0);
    offer(1'b1);
    offer(1'b0);

    // raise the limit: walk resumes, then stops again
    wait_idle();
    configure({1'b0, {(CRD_W-1){1'b1}}}, {1'b1, {(CRD_W-1){1'b0}}}, 4'd15, 24'd4);
    repeat (4) offer(1'b0);

    wait_idle();
    configure({1'b1, {(CRD_W-1){1'b0}}}, {1'b0, {(CRD_W-1){1'b1}}}, 4'd1, {NUM_W{1'b1}});
    repeat (5) offer(1'b0);
    offer(1'b1);

    while (rand_items < RANDOM_ITEMS) begin
      wait_idle();
      if (rand_items >= RANDOM_ITEMS - 30) calm = 1;
      configure(pick_origin(), pick_origin(), ULSP_SCALE_BITS'($urandom), pick_limit());
      if (phase == 1) hold_req = 1;
      len = $urandom_range(8, 24);
      repeat (len) begin
        offer($urandom_range(0, 11) == 0);
        rand_items++;
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (sb.n_checked < items_sent || sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Spiral run: %0d items, %0d restarts, %0d register settings",
             items_sent, restarts_sent, settings_done);
    $display("Results: %0d checked, %0d in range, %0d prime, %0d at the limit",
             sb.n_checked, sb.n_valid, sb.n_primes, sb.n_at_limit);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/ulsp_pkg.sv
design/ulsp_prime_div.sv
design/ulam_spiral_prime_plotter_core.sv
verif/testbench.sv
